// ===== sv/bas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_pkg
// Shared types, constants and helpers for the packed-BCD add/subtract/shift
// unit: operation and status codes, pipeline widths and the stage payload.
// ----------------------------------------------------------------------------
package bas_pkg;

    // port widths fixed by the interface
    localparam int DATA_W = 64;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // number size in decimal digits (2 to 16)
    localparam int DIGITS = 16;
    localparam int NUM_W  = 4 * DIGITS;

    // digit pipeline: each stage ripples the carry through one digit group
    localparam int STAGES     = 4;
    localparam int GROUP      = (DIGITS + STAGES - 1) / STAGES;
    localparam int GROUP_W    = 4 * GROUP;
    localparam int PAD_DIGITS = GROUP * STAGES;
    localparam int PAD_W      = 4 * PAD_DIGITS;

    // mask of the nibbles that belong to the number
    localparam logic [DATA_W-1:0] NUM_MASK = {DATA_W{1'b1}} >> (DATA_W - NUM_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_SUB   = 2'd1,
        CMD_MUL10 = 2'd2,
        CMD_DIV10 = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // payload carried from stage to stage
    typedef struct packed {
        cmd_t              cmd;
        logic [PAD_W-1:0]  a;      // digits not yet consumed, low group next
        logic [PAD_W-1:0]  b;
        logic [PAD_W-1:0]  r;      // finished digits enter from the top
        logic              carry;  // carry or borrow into the next group
        logic              top;    // carry or borrow out of the top digit
        logic [DATA_W-1:0] shr;    // shift result, worked out on entry
        logic              shovf;  // multiply-by-ten overflow
    } pipe_t;

    // marks the digit of a stage's group that is the number's top digit
    function automatic logic [GROUP-1:0] top_sel_of(input int stage);
        logic [GROUP-1:0] sel;
        sel = '0;
        for (int k = 0; k < GROUP; k++) begin
            sel[k] = ((stage * GROUP + k) == (DIGITS - 1));
        end
        return sel;
    endfunction

endpackage

// ===== sv/bcd_add_sub_shift_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_add_sub_shift_unit
// Packed-BCD add, subtract, multiply-by-ten and divide-by-ten, pipelined.
// ----------------------------------------------------------------------------
// A command is taken on every clock edge where start is high; busy is always
// low, so one command can be issued per cycle. Each result appears on
// result_value and status for exactly one cycle with done high, in issue
// order, after its command has passed the four stages of the decimal carry
// chain, four digits each, and then the output register. Nibbles above the
// number size read as zero.
// ----------------------------------------------------------------------------
module bcd_add_sub_shift_unit
    import bas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [DATA_W-1:0] operand_a,
    input  logic [DATA_W-1:0] operand_b,
    output logic              done,
    output logic [DATA_W-1:0] result_value,
    output logic [STAT_W-1:0] status
);

    logic              vld [STAGES+1];
    pipe_t             stg [STAGES+1];
    pipe_t             entry_data;
    logic [DATA_W-1:0] a_in;
    logic [DATA_W-1:0] b_in;
    logic              done_reg;
    logic [DATA_W-1:0] result_reg;
    logic [DATA_W-1:0] result_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [DATA_W-1:0] r_full;

    // the pipeline never holds off a command
    assign busy = 1'b0;

    // entry: drop nibbles above the number, work out the shifts
    assign a_in = operand_a & NUM_MASK;
    assign b_in = operand_b & NUM_MASK;

    always_comb
    begin
        entry_data.cmd   = cmd_t'(cmd);
        entry_data.a     = a_in[PAD_W-1:0];
        entry_data.b     = b_in[PAD_W-1:0];
        entry_data.r     = '0;
        entry_data.carry = 1'b0;
        entry_data.top   = 1'b0;
        entry_data.shovf = (a_in[NUM_W-1 -: 4] != 4'd0);
        if (cmd_t'(cmd) == CMD_MUL10)
        begin
            entry_data.shr = entry_data.shovf ? '0 : ((a_in << 4) & NUM_MASK);
        end
        else
        begin
            entry_data.shr = a_in >> 4;
        end
    end

    assign stg[0] = entry_data;
    assign vld[0] = start && !busy;

    // carry chain stages
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        bas_digit_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .top_sel   (top_sel_of(s)),
            .in_valid  (vld[s]),
            .in_data   (stg[s]),
            .out_valid (vld[s+1]),
            .out_data  (stg[s+1])
        );
    end

    // result and status select
    assign r_full = DATA_W'(stg[STAGES].r) & NUM_MASK;

    always_comb
    begin
        unique case (stg[STAGES].cmd)
            CMD_ADD:
            begin
                result_next = r_full;
                status_next = stg[STAGES].top ? ST_OVERFLOW : ST_OK;
            end
            CMD_SUB:
            begin
                result_next = stg[STAGES].top ? '0 : r_full;
                status_next = stg[STAGES].top ? ST_UNDERFLOW : ST_OK;
            end
            CMD_MUL10:
            begin
                result_next = stg[STAGES].shr;
                status_next = stg[STAGES].shovf ? ST_OVERFLOW : ST_OK;
            end
            default:
            begin
                result_next = stg[STAGES].shr;
                status_next = ST_OK;
            end
        endcase
    end

    // output strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld[STAGES];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

endmodule

// ===== sv/bas_digit_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_digit_stage
// One pipeline stage of the decimal carry chain: adds or subtracts the lowest
// digit group of the remaining operands and registers the partial result.
// ----------------------------------------------------------------------------
module bas_digit_stage
    import bas_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [GROUP-1:0] top_sel,
    input  logic             in_valid,
    input  pipe_t            in_data,
    output logic             out_valid,
    output pipe_t            out_data
);

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    // decimal add or borrow subtract over one digit group
    always_comb
    begin
        logic             c;
        logic             top;
        logic [3:0]       da;
        logic [3:0]       db;
        logic [4:0]       sum;
        logic [4:0]       fix;
        logic [GROUP_W-1:0] grp;
        c   = in_data.carry;
        top = in_data.top;
        grp = '0;
        for (int k = 0; k < GROUP; k++)
        begin
            da = in_data.a[4*k +: 4];
            db = in_data.b[4*k +: 4];
            if (in_data.cmd == CMD_SUB)
            begin
                sum = {1'b0, da} - {1'b0, db} - {4'b0, c};
                fix = sum + 5'd10;
                c   = sum[4];
                grp[4*k +: 4] = c ? fix[3:0] : sum[3:0];
            end
            else
            begin
                sum = {1'b0, da} + {1'b0, db} + {4'b0, c};
                fix = sum - 5'd10;
                c   = (sum > 5'd9);
                grp[4*k +: 4] = c ? fix[3:0] : sum[3:0];
            end
            if (top_sel[k])
            begin
                top = c;
            end
        end
        data_next       = in_data;
        data_next.a     = in_data.a >> GROUP_W;
        data_next.b     = in_data.b >> GROUP_W;
        data_next.r     = {grp, in_data.r[PAD_W-1:GROUP_W]};
        data_next.carry = c;
        data_next.top   = top;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/bas_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_checker
// Port-level checks for the BCD unit: fixed latency, no spurious results,
// and consistency between status codes and result values.
// ----------------------------------------------------------------------------
module bas_checker
    import bas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [DATA_W-1:0] operand_a,
    input  logic [DATA_W-1:0] operand_b,
    input  logic              done,
    input  logic [DATA_W-1:0] result_value,
    input  logic [STAT_W-1:0] status
);

    // every accepted command gives a result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("result missing five cycles after transfer");

    // no result without a command behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##5 !done)
        else $error("result without a matching transfer");

    // underflow only from subtract, and it clears the value
    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_UNDERFLOW) |->
            (result_value == '0 && $past(cmd, 5) == CMD_SUB))
        else $error("bad underflow result");

    // overflow never comes from subtract or divide
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_OVERFLOW) |->
            ($past(cmd, 5) == CMD_ADD || $past(cmd, 5) == CMD_MUL10))
        else $error("overflow from wrong operation");

    // nibbles above the number stay clear
    a_high_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result_value & ~NUM_MASK) == '0))
        else $error("result has digits above the number size");

endmodule

bind bcd_add_sub_shift_unit bas_checker u_bas_checker (.*);
